FILE: hw/rtl/pest_pkg.sv
//------------------------------------------------------------------------------
// pest_pkg: shared types and constants of the pending event slot table
//
// Status codes, field widths and the decision record that passes from the
// request decoder to the core.
//------------------------------------------------------------------------------
package pest_pkg;

	localparam int KIND_W     = 1;
	localparam int ID_W       = 8;
	localparam int SLOT_W     = 5;
	localparam int STATUS_W   = 3;
	localparam int CNT_W      = 5;
	localparam int DATA_W_MAX = 64;

	localparam logic [KIND_W-1:0] KIND_ADD  = 1'b0;
	localparam logic [KIND_W-1:0] KIND_TAKE = 1'b1;

	// An id of all ones on a take matches every slot.
	localparam logic [ID_W-1:0] ANY_ID = 8'hFF;

	localparam logic [CNT_W-1:0] NUM_EVENTS_RESET = 5'd24;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED  = 3'd0,
		ST_SKIPPED = 3'd1,
		ST_TAKEN   = 3'd2,
		ST_NONE    = 3'd3,
		ST_BAD_ID  = 3'd4
	} status_t;

	// What the decoder decided for one item.
	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic                mem_wr;
		logic                mem_rd;
	} pest_dec_t;

endpackage

FILE: hw/rtl/pest_if.sv
//------------------------------------------------------------------------------
// pest_req_if / pest_rsp_if: request and response channels
//
// Valid/ready channels; an item moves at a clock edge with valid and ready high.
//------------------------------------------------------------------------------
interface pest_req_if import pest_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [KIND_W-1:0]     kind;
	logic [ID_W-1:0]       event_id;
	logic                  overwrite;
	logic [DATA_W_MAX-1:0] data_in;

	modport source (output valid, input ready, output kind, output event_id,
		output overwrite, output data_in);
	modport sink (input valid, output ready, input kind, input event_id,
		input overwrite, input data_in);
endinterface

interface pest_rsp_if import pest_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_W-1:0]     slot;
	logic [DATA_W_MAX-1:0] data_out;

	modport source (output valid, input ready, output status, output slot,
		output data_out);
	modport sink (input valid, output ready, input status, input slot,
		input data_out);
endinterface

FILE: hw/rtl/pending_event_slot_table_core.sv
//------------------------------------------------------------------------------
// pending_event_slot_table_core: table of event slots with pending bits
//
// Channel   Dir   Payload                              Moves when
// req       in    kind, event_id, overwrite, data_in   req.valid && req.ready
// rsp       out   status, slot, data_out               rsp.valid && rsp.ready
// cfg       in    cfg_wdata (num_events)               cfg_we
//
// One item enters per cycle while rsp does not stall it; its result passes
// through stage one and the output register before it is presented on rsp.
// The data store is a synchronous memory with one write and one registered
// read per cycle; the pending mask lives in flip-flops so that every item
// sees the mask left by the one before it without any forwarding.
// Reset clears the pending mask and sets num_events to 24; the data store is
// not cleared and needs no clearing pass, since a slot is read only after an
// add has written it. A stall on rsp holds the item in stage one, and req
// stays ready as long as stage one can move on.
//------------------------------------------------------------------------------
module pending_event_slot_table_core import pest_pkg::*; #(
	parameter int SLOTS      = 24,
	parameter int DATA_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	pest_req_if.sink          req,
	pest_rsp_if.source        rsp
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Configuration register and pending bits.
	logic [CNT_W-1:0] num_events_q;
	logic [SLOTS-1:0] pend_q;

	// Decoder results for the item at the input.
	logic [SLOTS-1:0] pend_next;
	pest_dec_t        dec;

	// The data store and its registered read port.
	logic [DATA_WIDTH-1:0] slot_mem [SLOTS];
	logic [DATA_WIDTH-1:0] rd_data_s1;

	// Stage one: decision waiting for the memory read to land.
	logic                  valid_s1;
	status_t               status_s1;
	logic [SLOT_W-1:0]     slot_s1;

	// Output register.
	logic                  rsp_valid_q;
	logic [STATUS_W-1:0]   rsp_status_q;
	logic [SLOT_W-1:0]     rsp_slot_q;
	logic [DATA_W_MAX-1:0] rsp_data_q;

	logic acc;
	logic adv;

	pest_decode #(
		.SLOTS (SLOTS)
	) u_decode (
		.kind       (req.kind),
		.event_id   (req.event_id),
		.overwrite  (req.overwrite),
		.num_events (num_events_q),
		.pend       (pend_q),
		.pend_next  (pend_next),
		.dec        (dec)
	);

	// Stage one moves into the output register whenever that register is free
	// or is being emptied in this cycle.
	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign acc       = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_events_q <= NUM_EVENTS_RESET;
		end else if (cfg_we) begin
			num_events_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (acc) begin
			pend_q <= pend_next;
		end
	end

	// An add writes at its accept edge, so a take accepted in the next cycle
	// already reads the new word. The read register is loaded only by a take
	// and holds while stage one is stalled, because no new item enters then.
	always_ff @(posedge clk) begin
		if (acc && dec.mem_wr) begin
			slot_mem[dec.slot[SW-1:0]] <= req.data_in[DATA_WIDTH-1:0];
		end
		if (acc && dec.mem_rd) begin
			rd_data_s1 <= slot_mem[dec.slot[SW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= dec.status;
			slot_s1   <= dec.slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Only a taken result carries data; every other result shows zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_status_q <= status_s1;
			rsp_slot_q   <= slot_s1;
			rsp_data_q   <= (status_s1 == ST_TAKEN) ? DATA_W_MAX'(rd_data_s1) : '0;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.slot     = rsp_slot_q;
	assign rsp.data_out = rsp_data_q;

endmodule

FILE: hw/rtl/pest_decode.sv
//------------------------------------------------------------------------------
// pest_decode: request decoder and lowest-slot picker
//
// Checks the id against the slot count, matches the request against the
// pending bits, picks the lowest pending slot and forms the next pending mask.
//------------------------------------------------------------------------------
module pest_decode import pest_pkg::*; #(
	parameter int SLOTS = 24
) (
	input  logic [KIND_W-1:0] kind,
	input  logic [ID_W-1:0]   event_id,
	input  logic              overwrite,
	input  logic [CNT_W-1:0]  num_events,
	input  logic [SLOTS-1:0]  pend,
	output logic [SLOTS-1:0]  pend_next,
	output pest_dec_t         dec
);

	localparam int CW = $clog2(SLOTS + 1);

	logic [CW-1:0]    eff_cnt;
	logic             id_ok;
	logic             any_id;
	logic [SLOTS-1:0] id_hot;
	logic [SLOTS-1:0] hit;
	logic [SLOTS-1:0] low_hot;
	logic [SLOTS-1:0] want;
	logic [SLOTS-1:0] one;
	logic [SLOT_W-1:0] pick;

	assign one = SLOTS'(1);

	// A count above the slot total counts as the slot total.
	assign eff_cnt = (int'(num_events) > SLOTS) ? CW'(SLOTS) : CW'(num_events);
	assign id_ok   = ({1'b0, event_id} < 9'(eff_cnt));
	assign any_id  = (event_id == ANY_ID);

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			id_hot[i] = (event_id == ID_W'(i)) && id_ok;
		end
	end

	assign want    = any_id ? {SLOTS{1'b1}} : id_hot;
	assign hit     = want & pend;
	// Isolate the lowest set bit.
	assign low_hot = hit & (~hit + one);

	always_comb begin
		pick = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (low_hot[i]) begin
				pick = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		dec.status = ST_BAD_ID;
		dec.slot   = '0;
		dec.mem_wr = 1'b0;
		dec.mem_rd = 1'b0;
		pend_next  = pend;
		if (kind == KIND_ADD) begin
			if (id_ok) begin
				dec.slot = event_id[SLOT_W-1:0];
				if (!overwrite && (|(id_hot & pend))) begin
					dec.status = ST_SKIPPED;
				end else begin
					dec.status = ST_STORED;
					dec.mem_wr = 1'b1;
					pend_next  = pend | id_hot;
				end
			end
		end else begin
			if (any_id || id_ok) begin
				if (|hit) begin
					dec.status = ST_TAKEN;
					dec.slot   = pick;
					dec.mem_rd = 1'b1;
					pend_next  = pend & ~low_hot;
				end else begin
					dec.status = ST_NONE;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/pest_checker.sv
//------------------------------------------------------------------------------
// pest_checker: port-level checks of the pending event slot table
//
// Watches the response channel and checks the fixed shapes of the results.
//------------------------------------------------------------------------------
module pest_checker import pest_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic [STATUS_W-1:0]   rsp_status,
	input logic [SLOT_W-1:0]     rsp_slot,
	input logic [DATA_W_MAX-1:0] rsp_data_out
);

	// A stalled result keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_slot) && $stable(rsp_data_out))
		else $error("result changed while stalled");

	// Only a taken result carries a data word.
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_TAKEN) |-> (rsp_data_out == '0))
		else $error("data on a result that took nothing");

	// A take that found nothing names slot zero.
	a_none_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_NONE) |-> (rsp_slot == '0))
		else $error("none-pending result with a nonzero slot");

	// A rejected id names slot zero.
	a_bad_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_BAD_ID) |-> (rsp_slot == '0))
		else $error("bad-id result with a nonzero slot");

endmodule

bind pending_event_slot_table_core pest_checker u_pest_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_slot     (rsp.slot),
	.rsp_data_out (rsp.data_out)
);

FILE: verif/slot_table_checker.sv
//------------------------------------------------------------------------------
// slot_table_checker: result checker for the pending event slot table
//
// Watches the request and response channels and keeps its own copy of the
// pending bits, the slot data and num_events. Every accepted item is turned
// into the result it must produce. Every accepted result is compared with the
// oldest outstanding one.
//------------------------------------------------------------------------------
module slot_table_checker import pest_pkg::*; #(
	parameter int SLOTS      = 24,
	parameter int DATA_WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	pest_req_if              req,
	pest_rsp_if              rsp,
	output int               mismatches,
	output int               owed,
	output int               checked,
	output int               takes_hit
);

	localparam logic [DATA_W_MAX-1:0] DATA_MASK =
		(DATA_WIDTH >= DATA_W_MAX) ? '1 : ((64'd1 << DATA_WIDTH) - 64'd1);
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		status_t               status;
		logic [SLOT_W-1:0]     slot;
		logic [DATA_W_MAX-1:0] data;
	} slot_result_t;

	logic [SLOTS-1:0]      pend_bits;
	logic [DATA_W_MAX-1:0] slot_data [SLOTS];
	logic [CNT_W-1:0]      num_events;
	slot_result_t          owed_results [$];
	slot_result_t          oldest;
	int                    errors;
	int                    n_checked;
	int                    n_hits;

	initial begin
		errors    = 0;
		n_checked = 0;
		n_hits    = 0;
	end

	// Applies one item to the local copy of the table and returns its result.
	function automatic slot_result_t apply_request(logic [KIND_W-1:0] kind,
		logic [ID_W-1:0] id, logic ovr, logic [DATA_W_MAX-1:0] din);
		slot_result_t     r;
		int               count;
		logic [SLOTS-1:0] want;
		logic             named_ok;
		logic             found;
		r.status = ST_BAD_ID;
		r.slot   = '0;
		r.data   = '0;
		count    = (num_events > SLOTS) ? SLOTS : int'(num_events);
		if (kind == KIND_ADD) begin
			if (id < count) begin
				r.slot = id[SLOT_W-1:0];
				if (!ovr && pend_bits[id[SLOT_W-1:0]]) begin
					r.status = ST_SKIPPED;
				end else begin
					slot_data[id[SLOT_W-1:0]] = din & DATA_MASK;
					pend_bits[id[SLOT_W-1:0]] = 1'b1;
					r.status                  = ST_STORED;
				end
			end
		end else begin
			want     = '0;
			named_ok = 1'b1;
			if (id == ANY_ID) begin
				want = '1;
			end else if (id < count) begin
				want[id[SLOT_W-1:0]] = 1'b1;
			end else begin
				named_ok = 1'b0;
			end
			if (named_ok) begin
				r.status = ST_NONE;
				found    = 1'b0;
				for (int s = 0; s < SLOTS; s++) begin
					if (!found && want[s] && pend_bits[s]) begin
						found        = 1'b1;
						r.status     = ST_TAKEN;
						r.slot       = SLOT_W'(s);
						r.data       = slot_data[s];
						pend_bits[s] = 1'b0;
					end
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [DATA_W_MAX-1:0] got,
		logic [DATA_W_MAX-1:0] want);
		errors++;
		if (errors <= PRINT_CAP) begin
			$display("result %0d: %s is 0x%0h, should be 0x%0h", n_checked, what, got, want);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits  = '0;
			num_events = NUM_EVENTS_RESET;
			owed_results.delete();
		end else begin
			if (cfg_we) begin
				num_events = cfg_wdata;
			end
			if (req.valid && req.ready) begin
				owed_results.push_back(apply_request(req.kind, req.event_id,
					req.overwrite, req.data_in));
			end
			if (rsp.valid && rsp.ready) begin
				if (owed_results.size() == 0) begin
					report_mismatch("status of a result nobody asked for",
						DATA_W_MAX'(rsp.status), '0);
				end else begin
					oldest = owed_results.pop_front();
					if (rsp.status !== oldest.status) begin
						report_mismatch("status", DATA_W_MAX'(rsp.status),
							DATA_W_MAX'(oldest.status));
					end
					if (rsp.slot !== oldest.slot) begin
						report_mismatch("slot", DATA_W_MAX'(rsp.slot),
							DATA_W_MAX'(oldest.slot));
					end
					if (rsp.data_out !== oldest.data) begin
						report_mismatch("data_out", rsp.data_out, oldest.data);
					end
					if (oldest.status == ST_TAKEN) begin
						n_hits++;
					end
				end
				n_checked++;
			end
		end
		// Published through nonblocking assignments so the stimulus side never
		// races against this block at a shared clock edge.
		mismatches <= errors;
		owed       <= owed_results.size();
		checked    <= n_checked;
		takes_hit  <= n_hits;
	end

endmodule

FILE: verif/tb_top.sv
//------------------------------------------------------------------------------
// tb_top: testbench of the pending event slot table
//
// Drives requests and response back-pressure with random bursts of idling,
// walks num_events through its extremes and random values, and leaves result
// checking to slot_table_checker, whose failure and owed counts decide the verdict.
//------------------------------------------------------------------------------
module tb_top;
	import pest_pkg::*;

	localparam int SLOTS       = 24;
	localparam int DATA_WIDTH  = 64;
	// The limit leaves a wide margin over the slowest correct run.
	localparam int CYCLE_LIMIT = 500000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	// Stops idling on both channels for the closing stretch of the run.
	logic calm = 1'b0;

	int fails;
	int owed;
	int checked;
	int takes_hit;
	int items_sent = 0;
	int cycles = 0;

	pest_req_if req_ch ();
	pest_rsp_if rsp_ch ();

	pending_event_slot_table_core #(
		.SLOTS      (SLOTS),
		.DATA_WIDTH (DATA_WIDTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	slot_table_checker #(
		.SLOTS      (SLOTS),
		.DATA_WIDTH (DATA_WIDTH)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (fails),
		.owed       (owed),
		.checked    (checked),
		.takes_hit  (takes_hit)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The watchdog: a run that hangs anywhere ends here as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[pending_event_slot_table_core] ERROR");
			$finish;
		end
	end

	// Response back-pressure. Each cycle there is a small chance of a stall
	// burst, so stalls land on every phase of the pipeline, with long
	// stretches of full throughput in between.
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Presents one item and returns at the edge where it is accepted. Valid is
	// left high so the next item can follow back to back.
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
		input logic ovr, input logic [DATA_W_MAX-1:0] data);
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.kind      <= kind;
		req_ch.event_id  <= id;
		req_ch.overwrite <= ovr;
		req_ch.data_in   <= data;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// Brings the table to rest: no item offered, every result delivered, and
	// a wait that covers the two-stage pipeline.
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (owed != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_num_events(input logic [CNT_W-1:0] value);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// One random item. Most items name a slot that is in use, so adds and
	// takes keep the pending bits churning; a share are any-slot takes, and
	// the rest use an id from the whole 8-bit range, which mostly hits the
	// bad-id path and also covers an add with the any-slot id.
	task automatic random_item(input int in_use);
		int               pick;
		logic [ID_W-1:0]  id;
		logic [KIND_W-1:0] kind;
		pick = $urandom_range(0, 99);
		if (in_use > 0) begin
			id = ID_W'($urandom_range(0, in_use - 1));
		end else begin
			id = ID_W'($urandom_range(0, 255));
		end
		if (pick < 45) begin
			kind = KIND_ADD;
		end else if (pick < 70) begin
			kind = KIND_TAKE;
		end else if (pick < 88) begin
			kind = KIND_TAKE;
			id   = ANY_ID;
		end else begin
			kind = ($urandom_range(0, 1) == 1) ? KIND_TAKE : KIND_ADD;
			id   = ID_W'($urandom_range(0, 255));
		end
		send_item(kind, id, $urandom_range(0, 2) == 0, {$urandom, $urandom});
	endtask

	// A phase writes num_events while the table is at rest and then runs
	// random items under that setting. Pending bits carry over from phase to
	// phase, so lowering the count leaves bits above it for any-slot takes.
	task automatic run_phase(input logic [CNT_W-1:0] setting, input int n_items);
		int in_use;
		settle();
		write_num_events(setting);
		in_use = (setting > SLOTS) ? SLOTS : int'(setting);
		repeat (n_items) random_item(in_use);
	endtask

	initial begin
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_wdata        <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.kind      <= KIND_ADD;
		req_ch.event_id  <= '0;
		req_ch.overwrite <= 1'b0;
		req_ch.data_in   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with all 24 slots in use. It starts from an empty
		// table, so the first takes must find nothing pending.
		write_num_events(5'd24);
		send_item(KIND_TAKE, ANY_ID, 1'b0, '0);
		send_item(KIND_TAKE, 8'd0, 1'b0, '0);
		send_item(KIND_ADD, 8'd0, 1'b0, '1);
		// The slot is pending now: without overwrite the add is skipped,
		// with overwrite it replaces the data.
		send_item(KIND_ADD, 8'd0, 1'b0, 64'h0123_4567_89AB_CDEF);
		send_item(KIND_ADD, 8'd0, 1'b1, '0);
		send_item(KIND_ADD, 8'd23, 1'b1, 64'hA5A5_5A5A_A5A5_5A5A);
		// Bad ids: one past the last slot, the any-slot id on an add, and
		// large ids on both kinds.
		send_item(KIND_ADD, 8'd24, 1'b1, '1);
		send_item(KIND_ADD, ANY_ID, 1'b1, '1);
		send_item(KIND_ADD, 8'd128, 1'b0, '1);
		send_item(KIND_TAKE, 8'd24, 1'b0, '0);
		send_item(KIND_TAKE, 8'd254, 1'b0, '0);
		// A named take of the top slot, then any-slot takes drain slot 0
		// and find the table empty.
		send_item(KIND_TAKE, 8'd23, 1'b0, '0);
		send_item(KIND_TAKE, ANY_ID, 1'b1, '1);
		send_item(KIND_TAKE, ANY_ID, 1'b0, '0);
		// With several slots pending the lowest one wins an any-slot take.
		send_item(KIND_ADD, 8'd17, 1'b0, 64'h5A5A_A5A5_5A5A_A5A5);
		send_item(KIND_ADD, 8'd5, 1'b0, 64'hFFFF_0000_FFFF_0000);
		send_item(KIND_ADD, 8'd9, 1'b0, 64'h0000_FFFF_0000_FFFF);
		send_item(KIND_TAKE, 8'd17, 1'b0, '0);
		send_item(KIND_TAKE, 8'd17, 1'b0, '0);
		send_item(KIND_TAKE, ANY_ID, 1'b0, '0);
		send_item(KIND_TAKE, ANY_ID, 1'b0, '0);
		send_item(KIND_TAKE, ANY_ID, 1'b0, '0);

		// Random part over the extremes of num_events: full, a few slots,
		// one slot, none at all, and a value above the slot count.
		run_phase(5'd24, 300);
		run_phase(5'd5, 150);
		run_phase(5'd1, 100);
		run_phase(5'd0, 60);
		run_phase(5'd31, 200);
		repeat (5) run_phase(CNT_W'($urandom_range(0, 31)), 120);

		// Closing stretch at full rate on both channels.
		calm = 1'b1;
		run_phase(5'd24, 150);
		settle();

		$display("Sent %0d items and checked %0d results; %0d takes returned data.",
			items_sent, checked, takes_hit);
		$display("%s", {"num_events went through 0, 1, 5, 24, 31 and random values, ",
			"with idling on both sides."});
		if (fails == 0 && owed == 0) begin
			$display("[pending_event_slot_table_core] OK");
		end else begin
			$display("[pending_event_slot_table_core] ERROR");
		end
		$finish;
	end

endmodule
